// ----- src/stl_pkg.sv -----
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants for the SQL token lexer
// Record layout, result bundle, token kinds, error codes and character classes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stl_pkg;

  localparam int PosWidthDefault = 32;
  localparam int MaxResults      = 4;
  localparam int QueueDepth      = 4;

  // record types
  localparam logic [1:0] RT_TEXT  = 2'd0;
  localparam logic [1:0] RT_TOKEN = 2'd1;
  localparam logic [1:0] RT_ERROR = 2'd2;

  // token kinds
  localparam logic [4:0] K_END    = 5'd0;
  localparam logic [4:0] K_IDENT  = 5'd1;
  localparam logic [4:0] K_INT    = 5'd2;
  localparam logic [4:0] K_STR    = 5'd3;
  localparam logic [4:0] K_COMMA  = 5'd4;
  localparam logic [4:0] K_DOT    = 5'd5;
  localparam logic [4:0] K_LPAREN = 5'd6;
  localparam logic [4:0] K_RPAREN = 5'd7;
  localparam logic [4:0] K_STAR   = 5'd8;
  localparam logic [4:0] K_SEMI   = 5'd9;
  localparam logic [4:0] K_PLUS   = 5'd10;
  localparam logic [4:0] K_MINUS  = 5'd11;
  localparam logic [4:0] K_EQ     = 5'd12;
  localparam logic [4:0] K_NE     = 5'd13;
  localparam logic [4:0] K_LT     = 5'd14;
  localparam logic [4:0] K_LE     = 5'd15;
  localparam logic [4:0] K_GT     = 5'd16;
  localparam logic [4:0] K_GE     = 5'd17;

  // error codes
  localparam logic [1:0] E_COMMENT = 2'd0;
  localparam logic [1:0] E_NUL     = 2'd1;
  localparam logic [1:0] E_STRING  = 2'd2;
  localparam logic [1:0] E_CHAR    = 2'd3;

  // characters
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic [1:0]  rtype;
    logic [7:0]  text;
    logic [4:0]  kind;
    logic [1:0]  err;
    logic [31:0] off;
    logic [31:0] line;
    logic [31:0] col;
  } rec_t;

  // all results caused by one input item
  typedef struct packed {
    logic [2:0]                  cnt;
    rec_t [MaxResults-1:0]       recs;
  } bundle_t;

  function automatic logic letter_class(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
  endfunction

  function automatic logic digit_class(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic blank_class(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == CH_LF || b == CH_CR || b == 8'h0C;
  endfunction

  // kind of a one-character token, K_END when none
  function automatic logic [4:0] single_kind(input logic [7:0] b);
    logic [4:0] k;
    unique case (b)
      8'h2C:   k = K_COMMA;
      8'h2E:   k = K_DOT;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      CH_STAR: k = K_STAR;
      8'h3B:   k = K_SEMI;
      8'h2B:   k = K_PLUS;
      CH_EQ:   k = K_EQ;
      default: k = K_END;
    endcase
    return k;
  endfunction

endpackage

// ----- src/sql_token_lexer_core.sv -----
// ----------------------------------------------------------------------------
// sql_token_lexer_core: streaming SQL lexer
// One source byte or end item in, token text, token and error records out.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tdata[7:0] is a source byte; in_tuser high marks an end
//   item (byte ignored). One item transfers per cycle while in_tready is high.
//   Output stream: one record per transfer. out_tuser is the record type
//   (text byte, token, error); out_tlast marks the last record an input item
//   caused. Items that cause no record produce no transfer.
//   Path: an accepted item's bundle is written into the bundle queue, then
//   loaded into the back's bundle register, from which out_tvalid offers it.
//   The front takes one item per cycle and the back sends one record per
//   cycle with no gap between bundles; while out_tready stays high, the rate
//   is the slower of one item or one record per cycle (up to four per item).
//   A four-bundle queue between the two absorbs bursts; in_tready drops only
//   when that queue is full, so a stalled receiver backs up into the input.
//   Reset: lexer idle, offset 0, line and column 1, queue empty.
//   After an error record, bytes are dropped until the end item restarts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sql_token_lexer_core #(
  parameter int POSITION_WIDTH = stl_pkg::PosWidthDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] source_byte
  input  logic         in_tuser,   // [0] end_of_source
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // text_byte, token_kind, error_code,
                                   // start_offset, start_line, start_column, pad
  output logic [1:0]   out_tuser,  // [1:0] record_type
  output logic         out_tlast   // last_of_run
);
  import stl_pkg::*;

  logic    q_full, q_push, q_pop, q_empty;
  bundle_t q_in, q_out;
  rec_t    rec;

  stl_front #(.PosWidth(POSITION_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_end   (in_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  stl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  stl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rec   (rec),
    .out_last  (out_tlast)
  );

  // pack the record
  assign out_tuser = rec.rtype;
  assign out_tdata = {1'b0, rec.col, rec.line, rec.off, rec.err, rec.kind, rec.text};

endmodule

// ----- src/stl_front.sv -----
// ----------------------------------------------------------------------------
// stl_front: lexer state and classification
// Takes one item per cycle while the bundle queue is not full, updates
// position and lexer mode, and builds the bundle of records the item causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stl_front #(
  parameter int PosWidth = stl_pkg::PosWidthDefault
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_end,
  input  logic             q_full,
  output logic             q_push,
  output stl_pkg::bundle_t q_data
);
  import stl_pkg::*;

  localparam logic [3:0] M_IDLE      = 4'd0;
  localparam logic [3:0] M_IDENT     = 4'd1;
  localparam logic [3:0] M_INT       = 4'd2;
  localparam logic [3:0] M_STRING    = 4'd3;
  localparam logic [3:0] M_STRQ      = 4'd4;
  localparam logic [3:0] M_PMINUS    = 4'd5;
  localparam logic [3:0] M_PSLASH    = 4'd6;
  localparam logic [3:0] M_PLT       = 4'd7;
  localparam logic [3:0] M_PGT       = 4'd8;
  localparam logic [3:0] M_PBANG     = 4'd9;
  localparam logic [3:0] M_LINECMT   = 4'd10;
  localparam logic [3:0] M_BLOCK     = 4'd11;
  localparam logic [3:0] M_BLOCKSTAR = 4'd12;

  localparam logic [PosWidth-1:0] PosOne = PosWidth'(1);

  logic [3:0]          mode_r, mode_nxt;
  logic [PosWidth-1:0] off_r, off_nxt, line_r, line_nxt, col_r, col_nxt;
  logic                pcr_r, pcr_nxt;
  logic [PosWidth-1:0] ts_off_r, ts_off_nxt, ts_line_r, ts_line_nxt, ts_col_r, ts_col_nxt;
  logic                err_r, err_nxt;

  logic                accept;
  rec_t [MaxResults-1:0] recs;
  logic [2:0]          n;

  function automatic rec_t mk_text(input logic [7:0] b);
    rec_t r;
    r = '0;
    r.rtype = RT_TEXT;
    r.text  = b;
    return r;
  endfunction

  function automatic rec_t mk_pos(input logic [1:0] t, input logic [4:0] k,
                                  input logic [1:0] e, input logic [PosWidth-1:0] o,
                                  input logic [PosWidth-1:0] l,
                                  input logic [PosWidth-1:0] c);
    rec_t r;
    r = '0;
    r.rtype = t;
    r.kind  = k;
    r.err   = e;
    r.off   = 32'(o);
    r.line  = 32'(l);
    r.col   = 32'(c);
    return r;
  endfunction

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;

  // classification of the current item
  always_comb begin
    logic       st;
    logic [4:0] k;
    recs        = '0;
    n           = 3'd0;
    st          = 1'b0;
    k           = K_END;
    mode_nxt    = mode_r;
    off_nxt     = off_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    pcr_nxt     = pcr_r;
    ts_off_nxt  = ts_off_r;
    ts_line_nxt = ts_line_r;
    ts_col_nxt  = ts_col_r;
    err_nxt     = err_r;
    if (in_end) begin
      if (!err_r) begin
        // flush pending token
        priority case (mode_r)
          M_IDENT: begin
            recs[n[1:0]] = mk_pos(RT_TOKEN, K_IDENT, 2'd0, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
          end
          M_INT: begin
            recs[n[1:0]] = mk_pos(RT_TOKEN, K_INT, 2'd0, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
          end
          M_STRQ: begin
            recs[n[1:0]] = mk_pos(RT_TOKEN, K_STR, 2'd0, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
          end
          M_PMINUS: begin
            recs[n[1:0]] = mk_text(CH_MINUS);
            n = n + 3'd1;
            recs[n[1:0]] = mk_pos(RT_TOKEN, K_MINUS, 2'd0, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
          end
          M_PLT: begin
            recs[n[1:0]] = mk_text(CH_LT);
            n = n + 3'd1;
            recs[n[1:0]] = mk_pos(RT_TOKEN, K_LT, 2'd0, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
          end
          M_PGT: begin
            recs[n[1:0]] = mk_text(CH_GT);
            n = n + 3'd1;
            recs[n[1:0]] = mk_pos(RT_TOKEN, K_GT, 2'd0, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
          end
          M_PSLASH, M_PBANG: begin
            recs[n[1:0]] = mk_pos(RT_ERROR, K_END, E_CHAR, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
          end
          M_STRING: begin
            recs[n[1:0]] = mk_pos(RT_ERROR, K_END, E_STRING, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
          end
          M_BLOCK, M_BLOCKSTAR: begin
            recs[n[1:0]] = mk_pos(RT_ERROR, K_END, E_COMMENT, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
          end
          default: ;
        endcase
        // end token unless the flush failed
        if (!(mode_r == M_PSLASH || mode_r == M_PBANG || mode_r == M_STRING ||
              mode_r == M_BLOCK || mode_r == M_BLOCKSTAR)) begin
          recs[n[1:0]] = mk_pos(RT_TOKEN, K_END, 2'd0, off_r, line_r, col_r);
          n = n + 3'd1;
        end
      end
      // restart
      mode_nxt    = M_IDLE;
      off_nxt     = '0;
      line_nxt    = PosOne;
      col_nxt     = PosOne;
      pcr_nxt     = 1'b0;
      ts_off_nxt  = '0;
      ts_line_nxt = PosOne;
      ts_col_nxt  = PosOne;
      err_nxt     = 1'b0;
    end else if (!err_r) begin
      // mode step
      priority case (mode_r)
        M_IDENT: begin
          if (letter_class(in_byte) || digit_class(in_byte)) begin
            recs[n[1:0]] = mk_text(in_byte);
            n = n + 3'd1;
          end else begin
            recs[n[1:0]] = mk_pos(RT_TOKEN, K_IDENT, 2'd0, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
            st = 1'b1;
          end
        end
        M_INT: begin
          if (digit_class(in_byte)) begin
            recs[n[1:0]] = mk_text(in_byte);
            n = n + 3'd1;
          end else begin
            recs[n[1:0]] = mk_pos(RT_TOKEN, K_INT, 2'd0, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
            st = 1'b1;
          end
        end
        M_STRING: begin
          if (in_byte == CH_QUOTE) begin
            mode_nxt = M_STRQ;
          end else if (in_byte == CH_NUL) begin
            recs[n[1:0]] = mk_pos(RT_ERROR, K_END, E_NUL, off_r, line_r, col_r);
            n = n + 3'd1;
            err_nxt = 1'b1;
          end else begin
            recs[n[1:0]] = mk_text(in_byte);
            n = n + 3'd1;
          end
        end
        M_STRQ: begin
          if (in_byte == CH_QUOTE) begin
            recs[n[1:0]] = mk_text(CH_QUOTE);
            n = n + 3'd1;
            mode_nxt = M_STRING;
          end else begin
            recs[n[1:0]] = mk_pos(RT_TOKEN, K_STR, 2'd0, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
            st = 1'b1;
          end
        end
        M_PMINUS: begin
          if (in_byte == CH_MINUS) begin
            mode_nxt = M_LINECMT;
          end else begin
            recs[n[1:0]] = mk_text(CH_MINUS);
            n = n + 3'd1;
            recs[n[1:0]] = mk_pos(RT_TOKEN, K_MINUS, 2'd0, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
            st = 1'b1;
          end
        end
        M_PSLASH: begin
          if (in_byte == CH_STAR) begin
            mode_nxt = M_BLOCK;
          end else begin
            recs[n[1:0]] = mk_pos(RT_ERROR, K_END, E_CHAR, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
            err_nxt = 1'b1;
          end
        end
        M_PLT: begin
          recs[n[1:0]] = mk_text(CH_LT);
          n = n + 3'd1;
          if (in_byte == CH_EQ || in_byte == CH_GT) begin
            recs[n[1:0]] = mk_text(in_byte);
            n = n + 3'd1;
            recs[n[1:0]] = mk_pos(RT_TOKEN, (in_byte == CH_EQ) ? K_LE : K_NE, 2'd0,
                                  ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
            mode_nxt = M_IDLE;
          end else begin
            recs[n[1:0]] = mk_pos(RT_TOKEN, K_LT, 2'd0, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
            st = 1'b1;
          end
        end
        M_PGT: begin
          recs[n[1:0]] = mk_text(CH_GT);
          n = n + 3'd1;
          if (in_byte == CH_EQ) begin
            recs[n[1:0]] = mk_text(CH_EQ);
            n = n + 3'd1;
            recs[n[1:0]] = mk_pos(RT_TOKEN, K_GE, 2'd0, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
            mode_nxt = M_IDLE;
          end else begin
            recs[n[1:0]] = mk_pos(RT_TOKEN, K_GT, 2'd0, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
            st = 1'b1;
          end
        end
        M_PBANG: begin
          if (in_byte == CH_EQ) begin
            recs[n[1:0]] = mk_text(CH_BANG);
            n = n + 3'd1;
            recs[n[1:0]] = mk_text(CH_EQ);
            n = n + 3'd1;
            recs[n[1:0]] = mk_pos(RT_TOKEN, K_NE, 2'd0, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
            mode_nxt = M_IDLE;
          end else begin
            recs[n[1:0]] = mk_pos(RT_ERROR, K_END, E_CHAR, ts_off_r, ts_line_r, ts_col_r);
            n = n + 3'd1;
            err_nxt = 1'b1;
          end
        end
        M_LINECMT: begin
          if (in_byte == CH_LF || in_byte == CH_CR) mode_nxt = M_IDLE;
        end
        M_BLOCK: begin
          if (in_byte == CH_STAR) mode_nxt = M_BLOCKSTAR;
        end
        M_BLOCKSTAR: begin
          if (in_byte == CH_SLASH) mode_nxt = M_IDLE;
          else if (in_byte != CH_STAR) mode_nxt = M_BLOCK;
        end
        default: st = 1'b1;
      endcase

      // byte seen between tokens
      if (st) begin
        mode_nxt = M_IDLE;
        if (!blank_class(in_byte)) begin
          ts_off_nxt  = off_r;
          ts_line_nxt = line_r;
          ts_col_nxt  = col_r;
          k = single_kind(in_byte);
          if (letter_class(in_byte)) begin
            recs[n[1:0]] = mk_text(in_byte);
            n = n + 3'd1;
            mode_nxt = M_IDENT;
          end else if (digit_class(in_byte)) begin
            recs[n[1:0]] = mk_text(in_byte);
            n = n + 3'd1;
            mode_nxt = M_INT;
          end else if (in_byte == CH_QUOTE) begin
            mode_nxt = M_STRING;
          end else if (in_byte == CH_MINUS) begin
            mode_nxt = M_PMINUS;
          end else if (in_byte == CH_SLASH) begin
            mode_nxt = M_PSLASH;
          end else if (in_byte == CH_LT) begin
            mode_nxt = M_PLT;
          end else if (in_byte == CH_GT) begin
            mode_nxt = M_PGT;
          end else if (in_byte == CH_BANG) begin
            mode_nxt = M_PBANG;
          end else if (k != K_END) begin
            recs[n[1:0]] = mk_text(in_byte);
            n = n + 3'd1;
            recs[n[1:0]] = mk_pos(RT_TOKEN, k, 2'd0, off_r, line_r, col_r);
            n = n + 3'd1;
          end else begin
            recs[n[1:0]] = mk_pos(RT_ERROR, K_END, E_CHAR, off_r, line_r, col_r);
            n = n + 3'd1;
            err_nxt = 1'b1;
          end
        end
      end

      // position update; CRLF counts once
      if (in_byte == CH_CR) begin
        line_nxt = line_r + PosOne;
        col_nxt  = PosOne;
      end else if (in_byte == CH_LF) begin
        if (!pcr_r) line_nxt = line_r + PosOne;
        col_nxt = PosOne;
      end else begin
        col_nxt = col_r + PosOne;
      end
      pcr_nxt = (in_byte == CH_CR);
      off_nxt = off_r + PosOne;
    end
  end

  assign q_push      = accept && (n != 3'd0);
  assign q_data.cnt  = n;
  assign q_data.recs = recs;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      off_r     <= '0;
      line_r    <= PosOne;
      col_r     <= PosOne;
      pcr_r     <= 1'b0;
      ts_off_r  <= '0;
      ts_line_r <= PosOne;
      ts_col_r  <= PosOne;
      err_r     <= 1'b0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      off_r     <= off_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
      pcr_r     <= pcr_nxt;
      ts_off_r  <= ts_off_nxt;
      ts_line_r <= ts_line_nxt;
      ts_col_r  <= ts_col_nxt;
      err_r     <= err_nxt;
    end
  end

  // an end transfer always leaves a clean, idle lexer
  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end |=> mode_r == M_IDLE && !err_r && off_r == '0)
    else $error("lexer not restarted after end item");

  // an error record goes out only when not already in error
  a_no_err_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    err_r && !in_end |-> !q_push)
    else $error("results while in error state");

endmodule

// ----- src/stl_queue.sv -----
// ----------------------------------------------------------------------------
// stl_queue: bundle queue between front and back
// Small register FIFO of result bundles; push and pop may share a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  stl_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output stl_pkg::bundle_t pop_data
);
  import stl_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  bundle_t         mem [QueueDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;

  assign full     = (cnt_r == (PtrW+1)'(QueueDepth));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PtrW'(1);
      if (pop)  rp_r <= rp_r + PtrW'(1);
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("bundle queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("bundle queue underflow");

endmodule

// ----- src/stl_back.sv -----
// ----------------------------------------------------------------------------
// stl_back: result serializer
// Holds a bundle in a register and sends one record per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  stl_pkg::bundle_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output stl_pkg::rec_t    out_rec,
  output logic             out_last
);
  import stl_pkg::*;

  bundle_t    cur_r;
  logic [1:0] idx_r;
  logic       busy_r;
  logic       xfer, done, load;

  assign out_valid = busy_r;
  assign out_rec   = cur_r.recs[idx_r];
  assign out_last  = ({1'b0, idx_r} + 3'd1 == cur_r.cnt);
  assign xfer      = busy_r & out_ready;
  assign done      = xfer & out_last;
  assign load      = (!busy_r || done) && !q_empty;
  assign q_pop     = load;

  // bundle register
  always_ff @(posedge clk) begin
    if (load) cur_r <= q_data;
  end

  // record index and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (xfer) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> {1'b0, idx_r} < cur_r.cnt)
    else $error("record index past bundle count");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !out_ready |=> busy_r && $stable(idx_r))
    else $error("record moved while stalled");

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sql_token_lexer_core
// Streams directed and random SQL-like sources with random idles and stalls.
// Every expected record is predicted on input acceptance and compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import stl_pkg::*;

  typedef enum logic [3:0] {
    LX_IDLE, LX_IDENT, LX_INT, LX_STRING, LX_STRQ, LX_PMINUS, LX_PSLASH,
    LX_PLT, LX_PGT, LX_PBANG, LX_LINECMT, LX_BLOCK, LX_BLOCKSTAR
  } lex_state_t;

  typedef struct {
    logic [7:0] src;
    logic       eos;
    logic       drain;  // sender waits for all records before this one
  } src_item_t;

  typedef struct {
    logic [1:0]  rtype;
    logic [7:0]  text;
    logic [4:0]  kind;
    logic [1:0]  err;
    logic [31:0] off;
    logic [31:0] line;
    logic [31:0] col;
    logic        last;
  } lex_rec_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;   // [7:0] source_byte
  logic         in_tuser;   // [0] end_of_source
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;  // text, kind, err, offset, line, column, pad
  logic [1:0]   out_tuser;  // [1:0] record_type
  logic         out_tlast;

  src_item_t  src_q[$];
  lex_rec_t   record_q[$];
  lex_rec_t   item_recs[$];
  int         errors;
  int         accepted;
  int         src_wait;
  int         sink_wait;
  int         hold_cnt;
  bit         held_once;
  bit         burst;

  // lexer shadow state
  lex_state_t  lx_mode;
  logic [31:0] lx_off, lx_line, lx_col, tk_off, tk_line, tk_col;
  logic        lx_prev_cr, lx_err;

  sql_token_lexer_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------- predictor ----------------
  task automatic add_rec(input logic [1:0] rt, input logic [7:0] tx, input logic [4:0] k,
                         input logic [1:0] e, input logic [31:0] o, input logic [31:0] l,
                         input logic [31:0] c);
    lex_rec_t r;
    r.rtype = rt; r.text = tx; r.kind = k; r.err = e;
    r.off = o; r.line = l; r.col = c; r.last = 1'b0;
    if (item_recs.size() < MaxResults) item_recs = {item_recs, r};
  endtask

  task automatic add_text(input logic [7:0] b);
    add_rec(RT_TEXT, b, K_END, E_COMMENT, 0, 0, 0);
  endtask

  task automatic add_token(input logic [4:0] k);
    add_rec(RT_TOKEN, 8'd0, k, E_COMMENT, tk_off, tk_line, tk_col);
  endtask

  task automatic add_error(input logic [1:0] e, input logic [31:0] o, input logic [31:0] l,
                           input logic [31:0] c);
    add_rec(RT_ERROR, 8'd0, K_END, e, o, l, c);
    lx_err = 1'b1;
  endtask

  function automatic bit letter_ch(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic bit digit_ch(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit space_ch(input logic [7:0] b);
    return b == " " || b == 8'h09 || b == CH_LF || b == CH_CR || b == 8'h0C;
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] b);
    case (b)
      ",":     return K_COMMA;
      ".":     return K_DOT;
      "(":     return K_LPAREN;
      ")":     return K_RPAREN;
      CH_STAR: return K_STAR;
      ";":     return K_SEMI;
      "+":     return K_PLUS;
      CH_EQ:   return K_EQ;
      default: return K_END;
    endcase
  endfunction

  task automatic lex_reset();
    lx_mode = LX_IDLE; lx_off = 0; lx_line = 1; lx_col = 1; lx_prev_cr = 0;
    tk_off = 0; tk_line = 1; tk_col = 1; lx_err = 0;
  endtask

  // byte seen between tokens
  task automatic begin_token(input logic [7:0] b, input logic [31:0] o, input logic [31:0] l,
                             input logic [31:0] c);
    logic [4:0] k;
    lx_mode = LX_IDLE;
    if (!space_ch(b)) begin
      tk_off = o; tk_line = l; tk_col = c;
      k = punct_kind(b);
      if (letter_ch(b)) begin
        add_text(b); lx_mode = LX_IDENT;
      end else if (digit_ch(b)) begin
        add_text(b); lx_mode = LX_INT;
      end else if (b == CH_QUOTE) lx_mode = LX_STRING;
      else if (b == CH_MINUS) lx_mode = LX_PMINUS;
      else if (b == CH_SLASH) lx_mode = LX_PSLASH;
      else if (b == CH_LT) lx_mode = LX_PLT;
      else if (b == CH_GT) lx_mode = LX_PGT;
      else if (b == CH_BANG) lx_mode = LX_PBANG;
      else if (k != K_END) begin
        add_text(b); add_token(k);
      end else add_error(E_CHAR, o, l, c);
    end
  endtask

  task automatic lex_source_byte(input logic [7:0] b);
    logic [31:0] o, l, c;
    o = lx_off; l = lx_line; c = lx_col;
    case (lx_mode)
      LX_IDENT:
        if (letter_ch(b) || digit_ch(b)) add_text(b);
        else begin add_token(K_IDENT); begin_token(b, o, l, c); end
      LX_INT:
        if (digit_ch(b)) add_text(b);
        else begin add_token(K_INT); begin_token(b, o, l, c); end
      LX_STRING:
        if (b == CH_QUOTE) lx_mode = LX_STRQ;
        else if (b == CH_NUL) add_error(E_NUL, o, l, c);
        else add_text(b);
      LX_STRQ:
        if (b == CH_QUOTE) begin add_text(CH_QUOTE); lx_mode = LX_STRING; end
        else begin add_token(K_STR); begin_token(b, o, l, c); end
      LX_PMINUS:
        if (b == CH_MINUS) lx_mode = LX_LINECMT;
        else begin add_text(CH_MINUS); add_token(K_MINUS); begin_token(b, o, l, c); end
      LX_PSLASH:
        if (b == CH_STAR) lx_mode = LX_BLOCK;
        else add_error(E_CHAR, tk_off, tk_line, tk_col);
      LX_PLT:
        if (b == CH_EQ) begin
          add_text(CH_LT); add_text(CH_EQ); add_token(K_LE); lx_mode = LX_IDLE;
        end else if (b == CH_GT) begin
          add_text(CH_LT); add_text(CH_GT); add_token(K_NE); lx_mode = LX_IDLE;
        end else begin add_text(CH_LT); add_token(K_LT); begin_token(b, o, l, c); end
      LX_PGT:
        if (b == CH_EQ) begin
          add_text(CH_GT); add_text(CH_EQ); add_token(K_GE); lx_mode = LX_IDLE;
        end else begin add_text(CH_GT); add_token(K_GT); begin_token(b, o, l, c); end
      LX_PBANG:
        if (b == CH_EQ) begin
          add_text(CH_BANG); add_text(CH_EQ); add_token(K_NE); lx_mode = LX_IDLE;
        end else add_error(E_CHAR, tk_off, tk_line, tk_col);
      LX_LINECMT:
        if (b == CH_LF || b == CH_CR) lx_mode = LX_IDLE;
      LX_BLOCK:
        if (b == CH_STAR) lx_mode = LX_BLOCKSTAR;
      LX_BLOCKSTAR:
        if (b == CH_SLASH) lx_mode = LX_IDLE;
        else if (b != CH_STAR) lx_mode = LX_BLOCK;
      default: begin_token(b, o, l, c);
    endcase
    // position update; CRLF counts once
    if (b == CH_CR) begin
      lx_line = lx_line + 1; lx_col = 1;
    end else if (b == CH_LF) begin
      if (!lx_prev_cr) lx_line = lx_line + 1;
      lx_col = 1;
    end else lx_col = lx_col + 1;
    lx_prev_cr = (b == CH_CR);
    lx_off = lx_off + 1;
  endtask

  task automatic lex_end_of_source();
    bit failed;
    failed = 0;
    case (lx_mode)
      LX_IDENT:  add_token(K_IDENT);
      LX_INT:    add_token(K_INT);
      LX_STRQ:   add_token(K_STR);
      LX_PMINUS: begin add_text(CH_MINUS); add_token(K_MINUS); end
      LX_PLT:    begin add_text(CH_LT); add_token(K_LT); end
      LX_PGT:    begin add_text(CH_GT); add_token(K_GT); end
      LX_PSLASH, LX_PBANG: begin
        add_error(E_CHAR, tk_off, tk_line, tk_col); failed = 1;
      end
      LX_STRING: begin add_error(E_STRING, tk_off, tk_line, tk_col); failed = 1; end
      LX_BLOCK, LX_BLOCKSTAR: begin
        add_error(E_COMMENT, tk_off, tk_line, tk_col); failed = 1;
      end
      default: ;
    endcase
    if (!failed) add_rec(RT_TOKEN, 8'd0, K_END, E_COMMENT, lx_off, lx_line, lx_col);
  endtask

  // expected records for one accepted item
  task automatic predict_item(input logic [7:0] b, input logic eos);
    item_recs.delete();
    if (eos) begin
      if (!lx_err) lex_end_of_source();
      lex_reset();
    end else if (!lx_err) lex_source_byte(b);
    if (item_recs.size() > 0) item_recs[item_recs.size()-1].last = 1'b1;
    record_q = {record_q, item_recs};
  endtask

  // ---------------- stimulus builders ----------------
  task automatic put_byte(input logic [7:0] b);
    src_item_t it;
    it.src = b; it.eos = 1'b0; it.drain = 1'b0;
    src_q = {src_q, it};
  endtask

  task automatic put_text(input string s);
    foreach (s[i]) put_byte(s[i]);
  endtask

  task automatic put_end(input bit drain);
    src_item_t it;
    it.src = 8'($urandom); it.eos = 1'b1; it.drain = drain;
    src_q = {src_q, it};
  endtask

  task automatic put_random_token();
    string ops[] = '{",", ".", "(", ")", "*", ";", "+", "-", "=", "<", "<=", "<>",
                     ">", ">=", "!="};
    int n;
    logic [7:0] ch;
    case ($urandom_range(0, 11))
      0, 1: begin
        put_byte(8'("a" + $urandom_range(0, 25)));
        n = $urandom_range(0, 3);
        repeat (n) put_byte(8'($urandom_range(0, 1) ? "_" : "0" + $urandom_range(0, 9)));
      end
      2: begin
        n = $urandom_range(1, 3);
        repeat (n) put_byte(8'("0" + $urandom_range(0, 9)));
      end
      3: begin
        put_byte(CH_QUOTE);
        n = $urandom_range(0, 3);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            put_byte(CH_QUOTE); put_byte(CH_QUOTE);
          end else begin
            ch = 8'($urandom_range(1, 255));
            if (ch == CH_QUOTE) ch = "q";
            put_byte(ch);
          end
        end
        put_byte(CH_QUOTE);
      end
      4, 5, 6: put_text(ops[$urandom_range(0, ops.size()-1)]);
      7: put_text($urandom_range(0, 1) ? "--x\n" : "/* * */");
      8: begin
        put_byte(CH_CR);
        if ($urandom_range(0, 1)) put_byte(CH_LF);
      end
      9: put_byte($urandom_range(0, 1) ? 8'h09 : 8'h0C);
      10: put_byte(8'($urandom));  // noise
      default: put_byte(" ");
    endcase
    if ($urandom_range(0, 2) == 0) put_byte(" ");
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin
    src_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_item(in_tdata, in_tuser);
        accepted <= accepted + 1;
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered item
      end else if (src_wait > 0) begin
        src_wait <= src_wait - 1;
        in_tvalid <= 1'b0;
      end else if (src_q.size() > 0 && !(src_q[0].drain && record_q.size() > 0)) begin
        it = src_q.pop_front();
        in_tdata <= it.src;
        in_tuser <= it.eos;
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 40) == 0) burst = ~burst;
        src_wait <= burst ? 0 : $urandom_range(0, 4);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    lex_rec_t ex;
    logic [7:0]  a_text;
    logic [4:0]  a_kind;
    logic [1:0]  a_err;
    logic [31:0] a_off, a_line, a_col;
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_wait <= 0;
      hold_cnt <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        a_text = out_tdata[7:0];
        a_kind = out_tdata[12:8];
        a_err  = out_tdata[14:13];
        a_off  = out_tdata[46:15];
        a_line = out_tdata[78:47];
        a_col  = out_tdata[110:79];
        if (record_q.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected record type=%0d data=%h", $realtime, out_tuser, out_tdata);
        end else begin
          ex = record_q.pop_front();
          if (out_tuser !== ex.rtype || a_text !== ex.text || a_kind !== ex.kind ||
              a_err !== ex.err || a_off !== ex.off || a_line !== ex.line ||
              a_col !== ex.col || out_tlast !== ex.last) begin
            errors = errors + 1;
            $display({"%0t: mismatch expected type=%0d text=%h kind=%0d err=%0d",
                      " off=%0d line=%0d col=%0d last=%0d"},
                     $realtime, ex.rtype, ex.text, ex.kind, ex.err, ex.off, ex.line, ex.col,
                     ex.last);
            $display({"%0t:          actual type=%0d text=%h kind=%0d err=%0d",
                      " off=%0d line=%0d col=%0d last=%0d"},
                     $realtime, out_tuser, a_text, a_kind, a_err, a_off, a_line, a_col,
                     out_tlast);
          end
        end
      end
      // long hold-off once, so the internal queue fills and backs up the input
      if (!held_once && accepted >= 120) begin
        held_once <= 1'b1;
        hold_cnt <= 80;
        out_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait <= sink_wait - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        sink_wait <= burst ? 0 : $urandom_range(0, 4);
      end
    end
  end

  // ---------------- stimulus and end of run ----------------
  initial begin
    errors = 0; accepted = 0; held_once = 0; burst = 0;
    in_tvalid = 1'b0; in_tdata = 8'd0; in_tuser = 1'b0; out_tready = 1'b0;
    lex_reset();
    rst_n = 1'b0;

    // directed: every token kind but GE, whitespace forms, comments, string escapes
    put_text("Ab_9 0123,.()*;+-=<>=<=<>>!= 'it''s'");
    put_byte(CH_CR); put_byte(CH_LF);
    put_text("--c");
    put_byte(CH_CR);
    put_text("/*x**/\t");
    put_byte(8'h0C);
    put_byte(8'hFF);   // unknown byte: error, rest ignored
    put_byte(8'h00);
    put_end(1'b1);
    put_text("x-"); put_end(1'b0);          // pending minus flushed at end
    put_text("<"); put_end(1'b0);
    put_text(">"); put_end(1'b0);
    put_text("/x"); put_end(1'b0);          // lone slash
    put_text("!"); put_end(1'b0);           // lone bang at end
    put_text("'a"); put_byte(CH_NUL); put_end(1'b0);
    put_text(" 'ab"); put_end(1'b0);        // open string
    put_text("/* *"); put_end(1'b0);        // open comment
    put_text("''"); put_end(1'b1);

    // random well-formed sources with some noise
    while (src_q.size() < 360) begin
      repeat ($urandom_range(1, 8)) put_random_token();
      put_end($urandom_range(0, 5) == 0);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (src_q.size() != 0 || in_tvalid || record_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && record_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
